FILE: hdl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

    // Default configuration of the allocator.
    localparam int BLOCK_COUNT_DEF = 8;
    localparam int SIZE_BITS_DEF   = 16;

    // Fixed widths of the request and result fields.
    localparam int SEL_W    = 3;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;

    // Request kinds.
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_ALLOC = 1'b1
    } t_req_type;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_LOADED    = 2'd0,
        STATUS_ALLOCATED = 2'd1,
        STATUS_NO_FIT    = 2'd2
    } t_status;

    // Control from the top level to each cell; go and alloc are shared by all cells.
    typedef struct packed {
        logic go;        // a request is being resolved this cycle
        logic alloc;     // the request is an allocation
        logic load_hit;  // the request's block select addresses this cell
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hdl/first_fit_block_allocator.sv
`default_nettype none

// First-fit block allocator. A request is taken when start is high and busy
// is low, busy stays high for one cycle while the row of block cells
// resolves it, and the result appears with o_valid high for exactly one
// cycle; a new request may be started in that same cycle. The request is
// held in one register stage and resolved in one pass through the cell row,
// where every block compares its free size with the request and a claim bit
// ripples from block 0 upward so the lowest fitting block wins. The receiver
// cannot stall: a result that is not captured in its strobe cycle is lost.
// Load requests write one block's free size; allocations lower the chosen
// block's size by the request size. All block sizes are zero after reset.
module first_fit_block_allocator #(
    parameter int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT_DEF,
    parameter int SIZE_BITS   = ffba_pkg::SIZE_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_req_type,
    input  wire  [ffba_pkg::SEL_W-1:0]          i_block_select,
    input  wire  [ffba_pkg::FIELD_W-1:0]        i_size_value,
    output logic                                o_valid,
    output logic [ffba_pkg::STATUS_W-1:0]       o_result_status,
    output logic [ffba_pkg::SEL_W-1:0]          o_chosen_block,
    output logic [ffba_pkg::FIELD_W-1:0]        o_size_before,
    output logic [ffba_pkg::FIELD_W-1:0]        o_size_after
);

    localparam int IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    // Request register.
    logic                       r_busy;
    logic                       r_type;
    logic [ffba_pkg::SEL_W-1:0] r_sel;
    logic [SIZE_BITS-1:0]       r_size;

    // Result registers.
    logic                          r_valid;
    ffba_pkg::t_status             r_status;
    logic [ffba_pkg::SEL_W-1:0]    r_block;
    logic [ffba_pkg::FIELD_W-1:0]  r_before;
    logic [ffba_pkg::FIELD_W-1:0]  r_after;

    ffba_pkg::t_status             n_status;
    logic [ffba_pkg::SEL_W-1:0]    n_block;
    logic [SIZE_BITS-1:0]          n_before;
    logic [SIZE_BITS-1:0]          n_after;

    // Cell row signals.
    ffba_pkg::t_cell_ctl    w_ctl [BLOCK_COUNT];
    logic [BLOCK_COUNT:0]   w_claim;
    logic [BLOCK_COUNT-1:0] w_take;
    logic [BLOCK_COUNT-1:0] w_hit;
    logic [SIZE_BITS-1:0]   w_free [BLOCK_COUNT];

    logic                   w_accept;
    logic [IDX_W-1:0]       w_idx;
    logic [SIZE_BITS-1:0]   w_take_free;
    logic [SIZE_BITS-1:0]   w_hit_free;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // Capture a request and hold busy for the resolve cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_req_type;
            r_sel  <= i_block_select;
            r_size <= SIZE_BITS'(i_size_value);
        end
    end

    // Row of block cells with the claim bit running from block 0 upward.
    assign w_claim[0] = 1'b0;

    generate
        for (genvar k = 0; k < BLOCK_COUNT; k++) begin : g_cell
            assign w_hit[k]          = (32'(r_sel) == k);
            assign w_ctl[k].go       = r_busy;
            assign w_ctl[k].alloc    = (r_type == ffba_pkg::REQ_ALLOC);
            assign w_ctl[k].load_hit = w_hit[k];

            ffba_cell #(
                .SIZE_BITS (SIZE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[k]),
                .i_size      (r_size),
                .i_claim_in  (w_claim[k]),
                .o_claim_out (w_claim[k+1]),
                .o_take      (w_take[k]),
                .o_free      (w_free[k])
            );
        end
    endgenerate

    // Gather the index and size of the winning cell and of the loaded cell.
    always_comb begin
        w_idx       = '0;
        w_take_free = '0;
        w_hit_free  = '0;
        for (int k = 0; k < BLOCK_COUNT; k++) begin
            if (w_take[k]) begin
                w_idx       = w_idx | IDX_W'(k);
                w_take_free = w_take_free | w_free[k];
            end
            if (w_hit[k]) begin
                w_hit_free = w_hit_free | w_free[k];
            end
        end
    end

    // Form the result of the request being resolved; the claim bit that
    // leaves the last cell tells whether any block fits.
    always_comb begin
        if (r_type == ffba_pkg::REQ_LOAD) begin
            n_status = ffba_pkg::STATUS_LOADED;
            n_block  = r_sel;
            n_before = w_hit_free;
            n_after  = (|w_hit) ? r_size : '0;
        end else if (w_claim[BLOCK_COUNT]) begin
            n_status = ffba_pkg::STATUS_ALLOCATED;
            n_block  = ffba_pkg::SEL_W'(w_idx);
            n_before = w_take_free;
            n_after  = w_take_free - r_size;
        end else begin
            n_status = ffba_pkg::STATUS_NO_FIT;
            n_block  = '0;
            n_before = '0;
            n_after  = '0;
        end
    end

    // Result strobe and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_status <= n_status;
            r_block  <= n_block;
            r_before <= ffba_pkg::FIELD_W'(n_before);
            r_after  <= ffba_pkg::FIELD_W'(n_after);
        end
    end

    assign o_valid         = r_valid;
    assign o_result_status = r_status;
    assign o_chosen_block  = r_block;
    assign o_size_before   = r_before;
    assign o_size_after    = r_after;

    // At most one cell takes an allocation.
    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_take))
        else $error("more than one block took the allocation");

    // Only a request in the resolve cycle may change a block.
    a_take_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_take) |-> r_busy)
        else $error("block taken outside a resolve cycle");

    // Every accepted request yields a result strobe through the busy and valid registers.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_valid)
        else $error("accepted request gave no result");

    // A result strobe never follows a cycle without a request in flight.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !o_valid)
        else $error("result strobe without a request");

    // A failed allocation reports all-zero fields.
    a_no_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_status == ffba_pkg::STATUS_NO_FIT)) |->
        (o_chosen_block == '0 && o_size_before == '0 && o_size_after == '0))
        else $error("no-fit result carries nonzero fields");

endmodule

`default_nettype wire

FILE: hdl/ffba_cell.sv
`default_nettype none

module ffba_cell #(
    parameter int SIZE_BITS = ffba_pkg::SIZE_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire ffba_pkg::t_cell_ctl   i_ctl,
    input  wire  [SIZE_BITS-1:0]       i_size,
    input  wire                        i_claim_in,
    output logic                       o_claim_out,
    output logic                       o_take,
    output logic [SIZE_BITS-1:0]       o_free
);

    logic [SIZE_BITS-1:0] r_free;
    logic [SIZE_BITS-1:0] n_free;
    logic                 w_fit;

    // The block fits when its free size covers the request.
    assign w_fit = (r_free >= i_size);

    // The first fitting cell takes the request; later cells see it claimed.
    assign o_take      = i_ctl.go && i_ctl.alloc && w_fit && !i_claim_in;
    assign o_claim_out = i_claim_in || (i_ctl.alloc && w_fit);
    assign o_free      = r_free;

    // Next free size: a load overwrites it, an allocation lowers it.
    always_comb begin
        n_free = r_free;
        if (i_ctl.go && !i_ctl.alloc && i_ctl.load_hit) begin
            n_free = i_size;
        end else if (o_take) begin
            n_free = r_free - i_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '0;
        end else begin
            r_free <= n_free;
        end
    end

endmodule

`default_nettype wire
